[rtl/bia_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit interleaver address map - shared package
// Types, codes and constants shared by the datapath, the top and the testbench.
// ----------------------------------------------------------------------------
package bia_pkg;

    localparam int STAGES      = 6;
    localparam int IDX_W       = 19;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 2;

    localparam logic [18:0] MAIN_FRAME_BITS = 19'd365440;
    localparam logic [18:0] SEC_FRAME_BITS  = 19'd3200;
    localparam logic [10:0] SEC_K_OFFSET    = 11'd1142;

    // Reciprocals for division by a constant: x/5 = (x*RECIP5) >> 21 for
    // x below 2^18, x/9 = (x*RECIP9) >> 17 for x below 2^13,
    // x/10 = (x*RECIP10) >> 11 for x below 2^8, x/9 = (x*RECIP9_S) >> 9
    // for x below 2^6.
    localparam logic [18:0] RECIP5   = 19'd419431;
    localparam logic [13:0] RECIP9   = 14'd14564;
    localparam logic [7:0]  RECIP10  = 8'd205;
    localparam logic [5:0]  RECIP9_S = 6'd57;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENGINE = 2'd0,
        CFG_FACTOR = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic       engine;
        logic [1:0] factor_log2;
    } t_cfg;

    typedef struct packed {
        logic [STAGES-1:0] en;
    } t_pipe_ctl;

    typedef struct packed {
        logic [3:0] block_num;
        logic [4:0] row_num;
        logic [4:0] partition_num;
        logic [5:0] column_num;
        logic       in_range;
    } t_result;

    // Fixed partition order of the interleaver.
    function automatic logic [4:0] part_of(input logic [4:0] idx);
        logic [4:0] p;
        case (idx)
            5'd0:    p = 5'd10;
            5'd1:    p = 5'd2;
            5'd2:    p = 5'd18;
            5'd3:    p = 5'd6;
            5'd4:    p = 5'd14;
            5'd5:    p = 5'd8;
            5'd6:    p = 5'd16;
            5'd7:    p = 5'd0;
            5'd8:    p = 5'd12;
            5'd9:    p = 5'd4;
            5'd10:   p = 5'd11;
            5'd11:   p = 5'd3;
            5'd12:   p = 5'd19;
            5'd13:   p = 5'd7;
            5'd14:   p = 5'd15;
            5'd15:   p = 5'd9;
            5'd16:   p = 5'd17;
            5'd17:   p = 5'd1;
            5'd18:   p = 5'd13;
            5'd19:   p = 5'd5;
            default: p = 5'd0;
        endcase
        return p;
    endfunction

endpackage

[rtl/bia_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit interleaver address map - channel interfaces
// Offset input, address result and configuration write channels.
// ----------------------------------------------------------------------------
interface bia_in_if;
    logic        valid;
    logic        ready;
    logic [18:0] bit_index;

    modport source (output valid, output bit_index, input ready);
    modport sink   (input valid, input bit_index, output ready);
endinterface

interface bia_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] block_num;
    logic [4:0] row_num;
    logic [4:0] partition_num;
    logic [5:0] column_num;
    logic       in_range;

    modport source (output valid, output block_num, output row_num,
                    output partition_num, output column_num, output in_range,
                    input ready);
    modport sink   (input valid, input block_num, input row_num,
                    input partition_num, input column_num, input in_range,
                    output ready);
endinterface

interface bia_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/bia_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit interleaver address map - six-stage datapath
// Offset scaling, constant division, partition lookup and row/column mapping.
// ----------------------------------------------------------------------------
module bia_datapath (
    input  logic                 i_clk,
    input  bia_pkg::t_pipe_ctl   i_ctl,
    input  bia_pkg::t_cfg        i_cfg,
    input  logic [18:0]          i_bit_index,
    output bia_pkg::t_result     o_result
);
    import bia_pkg::*;

    // Stage 1: range check and scaled offset
    logic [18:0] r1_i;
    logic [19:0] r1_j;
    logic        r1_ok, r1_eng, r1_m1;
    logic [2:0]  n1_add;
    logic [19:0] n1_j;

    always_comb begin
        case (i_cfg.factor_log2)
            2'd2:    n1_add = 3'd2;
            2'd3:    n1_add = 3'd4;
            default: n1_add = 3'd0;
        endcase
        n1_j = ({1'b0, i_bit_index} + 20'(n1_add)) >> i_cfg.factor_log2;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r1_i   <= i_bit_index;
            r1_j   <= n1_j;
            r1_eng <= i_cfg.engine;
            r1_m1  <= (i_cfg.factor_log2 == 2'd0);
            r1_ok  <= i_cfg.engine ? (i_bit_index < SEC_FRAME_BITS)
                                   : (i_bit_index < MAIN_FRAME_BITS);
        end
    end

    // Stage 2: divide both offsets by 20
    logic [36:0] n2_pj, n2_pi;
    logic [14:0] r2_qj, r2_qi;
    logic [4:0]  r2_j5, r2_i5;
    logic        r2_ok, r2_eng, r2_m1;

    assign n2_pj = 37'(r1_j[19:2]) * 37'(RECIP5);
    assign n2_pi = 37'(r1_i[18:2]) * 37'(RECIP5);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r2_qj  <= n2_pj[35:21];
            r2_qi  <= n2_pi[35:21];
            r2_j5  <= r1_j[4:0];
            r2_i5  <= r1_i[4:0];
            r2_ok  <= r1_ok;
            r2_eng <= r1_eng;
            r2_m1  <= r1_m1;
        end
    end

    // Stage 3: remainders, k index and candidate blocks
    logic [4:0]  n3_pidx_main, n3_pidx_sec;
    logic [15:0] n3_p10;
    logic [4:0]  n3_q10;
    logic [3:0]  n3_rem10;
    logic [10:0] n3_k;
    logic [4:0]  r3_pidx;
    logic [10:0] r3_k;
    logic [3:0]  r3_blk_sec, r3_blk_alt, r3_q20lo;
    logic        r3_ok, r3_eng, r3_m1;

    always_comb begin
        // Only the low five bits of 20*q matter: the remainder is below 20.
        n3_pidx_main = r2_j5 - (5'({r2_qj[0], 4'd0}) + 5'({r2_qj[2:0], 2'd0}));
        n3_pidx_sec  = r2_i5 - (5'({r2_qi[0], 4'd0}) + 5'({r2_qi[2:0], 2'd0}));
        n3_p10       = 16'(r2_qi[7:0]) * 16'(RECIP10);
        n3_q10       = n3_p10[15:11];
        n3_rem10     = r2_qi[3:0] - (4'({n3_q10[2:0], 1'b0}) + 4'({n3_q10[0], 3'd0}));
        n3_k         = r2_eng ? (SEC_K_OFFSET + 11'(n3_rem10)) : r2_qi[14:4];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r3_pidx    <= r2_eng ? n3_pidx_sec : n3_pidx_main;
            r3_k       <= n3_k;
            r3_blk_sec <= n3_q10[3:0];
            r3_blk_alt <= r2_i5[3:0] + r2_qi[7:4];
            r3_q20lo   <= r2_qi[3:0];
            r3_ok      <= r2_ok;
            r3_eng     <= r2_eng;
            r3_m1      <= r2_m1;
        end
    end

    // Stage 4: partition, block, row and the column sum
    logic [4:0]  n4_part;
    logic [7:0]  n4_p7;
    logic [3:0]  n4_blk;
    logic [14:0] n4_k11;
    logic [11:0] n4_p57;
    logic [4:0]  r4_part, r4_row;
    logic [3:0]  r4_blk;
    logic [14:0] r4_s;
    logic        r4_ok;

    always_comb begin
        n4_part = part_of(r3_pidx);
        n4_p7   = 8'(n4_part) * 8'd7;
        if (r3_eng) begin
            n4_blk = r3_blk_sec;
        end else if (r3_m1) begin
            n4_blk = r3_q20lo + n4_p7[3:0];
        end else begin
            n4_blk = r3_blk_alt;
        end
        n4_k11 = 15'(r3_k) * 15'd11;
        n4_p57 = 12'(r3_k[10:5]) * 12'(RECIP9_S);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r4_part <= n4_part;
            r4_blk  <= n4_blk;
            r4_row  <= n4_k11[4:0];
            r4_s    <= n4_k11 + 15'(n4_p57[11:9]);
            r4_ok   <= r3_ok;
        end
    end

    // Stage 5: column sum divided by 36
    logic [26:0] n5_p9;
    logic [8:0]  r5_q;
    logic [14:0] r5_s;
    logic [4:0]  r5_part, r5_row;
    logic [3:0]  r5_blk;
    logic        r5_ok;

    assign n5_p9 = 27'(r4_s[14:2]) * 27'(RECIP9);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r5_q    <= n5_p9[25:17];
            r5_s    <= r4_s;
            r5_part <= r4_part;
            r5_row  <= r4_row;
            r5_blk  <= r4_blk;
            r5_ok   <= r4_ok;
        end
    end

    // Stage 6: column remainder, drop fields of an out-of-range offset
    logic [5:0] n6_col;
    t_result    r6_res;

    assign n6_col = r5_s[5:0] - (6'({r5_q[0], 5'd0}) + 6'({r5_q[3:0], 2'd0}));

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[5]) begin
            r6_res.in_range      <= r5_ok;
            r6_res.block_num     <= r5_ok ? r5_blk  : 4'd0;
            r6_res.row_num       <= r5_ok ? r5_row  : 5'd0;
            r6_res.partition_num <= r5_ok ? r5_part : 5'd0;
            r6_res.column_num    <= r5_ok ? n6_col  : 6'd0;
        end
    end

    assign o_result = r6_res;

endmodule

[rtl/bit_interleaver_address_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit interleaver address map - top level
// Maps a bit offset of a transfer frame to block, row, partition and column.
// ----------------------------------------------------------------------------
// Pipeline: six register stages; an accepted offset moves through them in turn
//   and its result is valid on the output once it reaches the last one.
// Throughput: 1 item per cycle without stalls; the six-stage pipeline sets it,
//   and constant dividers (by 20, 10, 288, 36) each sit in a stage of their own.
// Stall: a stage advances only when the one after it is empty or moving.
// Reset: synchronous, active low; clears stage valid bits and both registers.
// ----------------------------------------------------------------------------
module bit_interleaver_address_map (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bia_cfg_if.sink    i_cfg,
    bia_in_if.sink     i_in,
    bia_out_if.source  o_out
);
    import bia_pkg::*;

    // Configuration registers, always ready.
    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_ENGINE: r_cfg.engine      <= i_cfg.data[0];
                CFG_FACTOR: r_cfg.factor_log2 <= i_cfg.data;
                default:    r_cfg             <= r_cfg;  // drop unknown index
            endcase
        end
    end

    // Valid bits travel with the stage registers. A stage may load when it
    // is empty or when its item moves on in the same cycle.
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] adv;
    logic [STAGES-1:0] src_vld;
    t_pipe_ctl         ctl;

    always_comb begin
        adv[STAGES-1] = !r_vld[STAGES-1] || o_out.ready;
        for (int s = STAGES - 2; s >= 0; s--) begin
            adv[s] = !r_vld[s] || adv[s+1];
        end
        src_vld = {r_vld[STAGES-2:0], i_in.valid};
        ctl.en  = adv & src_vld;  // hold payload registers when nothing arrives
    end

    assign i_in.ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < STAGES; s++) begin
                if (adv[s]) begin
                    r_vld[s] <= src_vld[s];
                end
            end
        end
    end

    // Datapath
    t_result res;

    bia_datapath u_datapath (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_cfg       (r_cfg),
        .i_bit_index (i_in.bit_index),
        .o_result    (res)
    );

    assign o_out.valid         = r_vld[STAGES-1];
    assign o_out.block_num     = res.block_num;
    assign o_out.row_num       = res.row_num;
    assign o_out.partition_num = res.partition_num;
    assign o_out.column_num    = res.column_num;
    assign o_out.in_range      = res.in_range;

    // Checks
    a_fields_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.in_range |->
            (o_out.partition_num < 5'd20) && (o_out.column_num < 6'd36))
        else $error("partition or column out of bounds");

    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.in_range |->
            (o_out.block_num == 4'd0) && (o_out.row_num == 5'd0) &&
            (o_out.partition_num == 5'd0) && (o_out.column_num == 6'd0))
        else $error("out-of-range item carries nonzero fields");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[0])
        else $error("accepted item lost at first stage");

    a_empty_tail_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[STAGES-1] |-> i_in.ready)
        else $error("input stalled while output stage empty");

endmodule

[bench/bit_interleaver_address_map_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit interleaver address map - testbench
// Drives bit offsets through both engines and every interleave factor, checks
// each address against a behavioral predictor or a typed-in value, and randomizes
// idle cycles on the offset and address channels around a fixed directed sweep.
// ----------------------------------------------------------------------------
module bit_interleaver_address_map_tb;
    import bia_pkg::*;

    // Run limit in clock cycles; far beyond the slowest legal run.
    localparam int unsigned CYCLE_LIMIT = 500000;
    // Addresses still in flight after the last one expected: six stages.
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned ITEMS_PER_PHASE = 170;
    localparam int unsigned PHASE_COUNT = 8;
    localparam int unsigned HOLD_CYCLES = 80;

    // Register indexes that the block does not implement.
    localparam logic [1:0] SPARE_REG_FIRST = 2'd2;
    localparam logic [1:0] SPARE_REG_LAST  = 2'd3;

    localparam t_cfg MAIN_M1 = '{1'b0, 2'd0};
    localparam t_cfg MAIN_M2 = '{1'b0, 2'd1};
    localparam t_cfg MAIN_M4 = '{1'b0, 2'd2};
    localparam t_cfg MAIN_M8 = '{1'b0, 2'd3};
    localparam t_cfg SEC_M1  = '{1'b1, 2'd0};
    localparam t_cfg SEC_M8  = '{1'b1, 2'd3};

    localparam t_result NO_FIX       = '0;
    localparam t_result OUT_OF_FRAME = '0;

    // Interleaver partition order, walked by the partition index.
    localparam logic [4:0] PART_ORDER [20] = '{
        5'd10, 5'd2, 5'd18, 5'd6, 5'd14, 5'd8, 5'd16, 5'd0, 5'd12, 5'd4,
        5'd11, 5'd3, 5'd19, 5'd7, 5'd15, 5'd9, 5'd17, 5'd1, 5'd13, 5'd5
    };

    typedef struct {
        t_cfg        setting;
        logic [18:0] bit_index;
        bit          has_fixed;
        t_result     fixed;
    } t_probe;

    logic i_clk;
    logic i_rst_n;

    bia_cfg_if cfg_ch ();
    bia_in_if  in_ch ();
    bia_out_if out_ch ();

    bit_interleaver_address_map dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Addresses owed by the block, oldest first.
    t_result     address_q [$];
    // Register contents as the block should hold them, updated on each write.
    t_cfg        mapped_setting;
    // Setting last written by the stimulus.
    t_cfg        target_setting;
    // Typed-in address for the item on offer, when the directed row has one.
    bit          fixed_pending;
    t_result     fixed_value;
    int unsigned errors;
    int unsigned cycle_count;
    // Traffic controls: no stalls or gaps, one long receiver hold-off, a sender burst.
    bit          no_idle;
    bit          rx_hold_req;
    bit          tx_burst;

    // Directed sweep: reset defaults, frame edges, every factor, both engines.
    t_probe probes [25] = '{
        '{MAIN_M1, 19'd0,      1'b1, '{4'd6, 5'd0, 5'd10, 6'd0, 1'b1}},
        '{MAIN_M1, 19'd365439, 1'b1, '{4'd2, 5'd7, 5'd5, 6'd26, 1'b1}},
        '{MAIN_M1, 19'd365440, 1'b1, OUT_OF_FRAME},
        '{MAIN_M1, 19'd524287, 1'b1, OUT_OF_FRAME},
        '{MAIN_M1, 19'd19,     1'b0, NO_FIX},
        '{MAIN_M1, 19'd320,    1'b0, NO_FIX},
        '{MAIN_M1, 19'd92160,  1'b0, NO_FIX},
        '{MAIN_M1, 19'd262143, 1'b0, NO_FIX},
        '{MAIN_M2, 19'd0,      1'b0, NO_FIX},
        '{MAIN_M2, 19'd1,      1'b0, NO_FIX},
        '{MAIN_M2, 19'd365439, 1'b0, NO_FIX},
        '{MAIN_M4, 19'd1,      1'b0, NO_FIX},
        '{MAIN_M4, 19'd2,      1'b0, NO_FIX},
        '{MAIN_M4, 19'd79,     1'b0, NO_FIX},
        '{MAIN_M8, 19'd3,      1'b0, NO_FIX},
        '{MAIN_M8, 19'd4,      1'b0, NO_FIX},
        '{MAIN_M8, 19'd365440, 1'b1, OUT_OF_FRAME},
        '{SEC_M1,  19'd0,      1'b1, '{4'd0, 5'd18, 5'd10, 6'd1, 1'b1}},
        '{SEC_M1,  19'd3199,   1'b0, NO_FIX},
        '{SEC_M1,  19'd3200,   1'b1, OUT_OF_FRAME},
        '{SEC_M8,  19'd199,    1'b0, NO_FIX},
        '{SEC_M8,  19'd200,    1'b0, NO_FIX},
        '{SEC_M8,  19'd1999,   1'b0, NO_FIX},
        '{SEC_M8,  19'd524287, 1'b1, OUT_OF_FRAME},
        '{MAIN_M1, 19'd100000, 1'b0, NO_FIX}
    };

    // Clock: 2 ns period.
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Compute where one bit offset lands under the given register setting.
    function automatic t_result map_bit_offset(input logic [18:0] offset, input t_cfg setting);
        t_result     addr;
        int unsigned i;
        int unsigned m;
        int unsigned part;
        int unsigned blk;
        int unsigned k;
        bit          ok;
        addr = '0;
        i = offset;
        if (!setting.engine) begin
            // Main engine: partition follows the offset scaled by M, rounded for M>2.
            m = 1 << setting.factor_log2;
            ok = i < MAIN_FRAME_BITS;
            part = PART_ORDER[((i + 2 * (m / 4)) / m) % 20];
            if (m == 1) begin
                blk = (i / 20 + part * 7) % 16;
            end else begin
                blk = (i + i / 320) % 16;
            end
            k = i / 320;
        end else begin
            // Second engine: factor plays no part.
            ok = i < SEC_FRAME_BITS;
            part = PART_ORDER[i % 20];
            blk = (i / 200) % 16;
            k = (i / 20) % 10 + SEC_K_OFFSET;
        end
        if (ok) begin
            addr.block_num     = 4'(blk);
            addr.row_num       = 5'((k * 11) % 32);
            addr.partition_num = 5'(part);
            addr.column_num    = 6'((k * 11 + k / 288) % 36);
            addr.in_range      = 1'b1;
        end
        return addr;
    endfunction

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
    endtask

    // Sample every handshake at the rising edge; predict on accept, check on result.
    always @(posedge i_clk) begin : scoreboard
        t_result want;
        t_result got;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else if (i_rst_n) begin
            // Track register writes; unknown indexes leave both untouched.
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == CFG_ENGINE) begin
                    mapped_setting.engine = cfg_ch.data[0];
                end else if (cfg_ch.index == CFG_FACTOR) begin
                    mapped_setting.factor_log2 = cfg_ch.data;
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.block_num, out_ch.row_num, out_ch.partition_num,
                        out_ch.column_num, out_ch.in_range};
                if (address_q.size() == 0) begin
                    $display("%0t ns: unexpected address, expected none, actual %p",
                             $time, got);
                    errors++;
                end else begin
                    want = address_q.pop_front();
                    if (got.block_num != want.block_num)
                        report_field("block_num", want.block_num, got.block_num);
                    if (got.row_num != want.row_num)
                        report_field("row_num", want.row_num, got.row_num);
                    if (got.partition_num != want.partition_num)
                        report_field("partition_num", want.partition_num, got.partition_num);
                    if (got.column_num != want.column_num)
                        report_field("column_num", want.column_num, got.column_num);
                    if (got.in_range != want.in_range)
                        report_field("in_range", want.in_range, got.in_range);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                if (fixed_pending) begin
                    address_q.push_back(fixed_value);
                end else begin
                    address_q.push_back(map_bit_offset(in_ch.bit_index, mapped_setting));
                end
            end
        end
    end

    // Receiver: mostly ready, short stalls, occasional long ones, and one
    // long hold-off on request while the sender keeps pushing.
    initial begin : receiver
        int unsigned stall_left;
        int unsigned roll;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left != 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end else if (no_idle) begin
                out_ch.ready <= 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    out_ch.ready <= 1'b1;
                end else if (roll < 95) begin
                    stall_left = $urandom_range(0, 3);
                    out_ch.ready <= 1'b0;
                end else begin
                    stall_left = $urandom_range(8, 30);
                    out_ch.ready <= 1'b0;
                end
            end
        end
    end

    // Idle cycles before the next offset: mostly none, some short, a few long.
    function automatic int unsigned gap_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_idle || tx_burst) return 0;
        if (roll < 65) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // Mostly offsets inside the frame, some around its edge, some anywhere.
    function automatic logic [18:0] pick_offset(input t_cfg setting);
        int unsigned frame;
        int unsigned roll;
        frame = setting.engine ? SEC_FRAME_BITS : MAIN_FRAME_BITS;
        roll = $urandom_range(0, 99);
        if (roll < 80) return 19'($urandom_range(0, frame - 1));
        if (roll < 90) return 19'(frame - 4 + $urandom_range(0, 7));
        return 19'($urandom_range(0, 524287));
    endfunction

    // Offer one offset after an idle gap and hold it until accepted.
    task automatic push_offset(input logic [18:0] offset, input int unsigned gap,
                               input bit use_fixed, input t_result fixed);
        if (gap != 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.bit_index <= offset;
        fixed_pending = use_fixed;
        fixed_value = fixed;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Drop the offer and wait until every owed address has come back.
    task automatic drain_offsets();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (address_q.size() != 0) @(posedge i_clk);
    endtask

    // Write one register; valid stays up for a following write.
    task automatic cfg_write(input logic [1:0] index, input logic [1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // Reprogram both registers while the block is empty; poke an unused
    // index too, and set the unused engine bit at random.
    task automatic change_setting(input t_cfg setting);
        drain_offsets();
        cfg_write($urandom_range(0, 1) ? SPARE_REG_LAST : SPARE_REG_FIRST,
                  2'($urandom_range(0, 3)));
        cfg_write(CFG_ENGINE, {1'($urandom_range(0, 1)), setting.engine});
        cfg_write(CFG_FACTOR, setting.factor_log2);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        target_setting = setting;
    endtask

    initial begin : stimulus
        t_cfg        phase_setting [PHASE_COUNT];
        int unsigned n;
        int unsigned gap;
        // Drive every input known before the first edge.
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.bit_index = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        fixed_pending = 1'b0;
        fixed_value = '0;
        errors = 0;
        cycle_count = 0;
        no_idle = 1'b0;
        rx_hold_req = 1'b0;
        tx_burst = 1'b0;
        mapped_setting = MAIN_M1;
        target_setting = MAIN_M1;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sweep; the first rows run on the reset values.
        foreach (probes[r]) begin
            if (probes[r].setting != target_setting) change_setting(probes[r].setting);
            push_offset(probes[r].bit_index, gap_len(), probes[r].has_fixed, probes[r].fixed);
        end

        // Random phases: six fixed settings first, then two drawn at random.
        phase_setting = '{MAIN_M1, MAIN_M8, SEC_M1, MAIN_M2, SEC_M8, MAIN_M4,
                          '{1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))},
                          '{1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))}};
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            change_setting(phase_setting[ph]);
            // One phase runs with no idle cycles on either side.
            no_idle = (ph == 1);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Hold the receiver off while offering back to back: fill the pipe.
                if (ph == 2 && n == 40) rx_hold_req = 1'b1;
                tx_burst = (ph == 2 && n >= 40 && n < 130);
                // Pause the sender until every address is back.
                if (ph == 3 && n == 85) drain_offsets();
                gap = gap_len();
                push_offset(pick_offset(target_setting), gap, 1'b0, NO_FIX);
            end
            tx_burst = 1'b0;
        end
        no_idle = 1'b0;

        drain_offsets();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && address_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[bit_interleaver_address_map.f]
rtl/bia_pkg.sv
rtl/bia_if.sv
rtl/bia_datapath.sv
rtl/bit_interleaver_address_map.sv
bench/bit_interleaver_address_map_tb.sv
